// ===== src/quad_encoder_speed_meter_unit_assert.svh =====
// Assertion macros for the quadrature encoder speed meter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef QUAD_ENCODER_SPEED_METER_UNIT_ASSERT_SVH
`define QUAD_ENCODER_SPEED_METER_UNIT_ASSERT_SVH

// same-cycle implication
`define QESM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QESM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qesm_pkg.sv =====
// Shared types, constants and the x4 step table for the encoder speed meter.
// No dependencies.
package qesm_pkg;

    localparam int NUM_SLOTS = 3;
    localparam int CHANNELS  = 3;

    localparam int CNT_W  = 16;
    localparam int POS_W  = 32;
    localparam int IDLE_W = 8;
    localparam int WIN_W  = 16;
    localparam int SPD_W  = 32;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] CFG_WINDOW_TICKS   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IDLE_LIMIT     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_VELOCITY_SCALE = 2'd2;

    localparam logic [WIN_W-1:0]  RST_WINDOW_TICKS   = 16'd100;
    localparam logic [IDLE_W-1:0] RST_IDLE_LIMIT     = 8'd50;
    localparam logic [CFG_W-1:0]  RST_VELOCITY_SCALE = 16'd0;

    typedef struct packed {
        logic [CNT_W-1:0] pulses;
        logic             reverse;
    } t_lane_out;

    // Pins coded {A,B}. Forward Gray order 00 -> 10 -> 11 -> 01 -> 00.
    function automatic logic [1:0] fwd_next(input logic [1:0] pins);
        logic [1:0] r;
        case (pins)
            2'b00:   r = 2'b10;
            2'b01:   r = 2'b00;
            2'b10:   r = 2'b11;
            default: r = 2'b01;
        endcase
        return r;
    endfunction

    // +1 forward, -1 reverse, 0 for no move or a double flip
    function automatic logic [POS_W-1:0] quad_step(input logic [1:0] prev,
                                                   input logic [1:0] cur);
        logic [POS_W-1:0] r;
        if (fwd_next(prev) == cur) begin
            r = POS_W'(1);
        end else if (fwd_next(cur) == prev) begin
            r = '1;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== src/qesm_lane.sv =====
// One encoder channel: x4 decode, change counter, idle clear, window hold.
// Depends on qesm_pkg.
module qesm_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [1:0]                   i_pins,
    input  logic [qesm_pkg::IDLE_W-1:0]  i_idle_limit,
    input  logic                         i_latch,
    output qesm_pkg::t_lane_out          o_held
);
    import qesm_pkg::*;

    logic [1:0]        r_last;
    logic [CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_pos;
    logic [IDLE_W-1:0] r_idle;
    t_lane_out         r_held;

    logic [CNT_W-1:0]  n_cnt;
    logic [POS_W-1:0]  n_pos;
    logic [IDLE_W-1:0] n_idle;
    logic [1:0]        n_last;
    t_lane_out         n_held;

    always_comb begin
        n_last = r_last;
        n_cnt  = r_cnt;
        n_pos  = r_pos;
        n_idle = r_idle;
        n_held = r_held;
        if (i_pins != r_last) begin
            n_idle = '0;
            n_pos  = r_pos + quad_step(r_last, i_pins);
            if (r_cnt != '1) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            n_last = i_pins;
        end else begin
            if (r_idle != '1) begin
                n_idle = r_idle + IDLE_W'(1);
            end
            if (n_idle > i_idle_limit) begin
                n_cnt = '0;
                n_pos = '0;
            end
        end
        if (i_latch) begin
            n_held.pulses  = n_cnt;
            n_held.reverse = n_pos[POS_W-1];
            n_cnt          = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_cnt  <= '0;
            r_pos  <= '0;
            r_idle <= '0;
            r_held <= '0;
        end else if (i_en) begin
            r_last <= n_last;
            r_cnt  <= n_cnt;
            r_pos  <= n_pos;
            r_idle <= n_idle;
            r_held <= n_held;
        end
    end

    assign o_held = r_held;

endmodule

// ===== src/qesm_merge.sv =====
// Output stage: gathers lane holds, scales them to speed, registers the word.
// Depends on qesm_pkg.
module qesm_merge (
    input  logic                                            i_clk,
    input  logic                                            i_load,
    input  qesm_pkg::t_lane_out [qesm_pkg::NUM_SLOTS-1:0]   i_lane,
    input  logic                                            i_done,
    input  logic [qesm_pkg::CFG_W-1:0]                      i_scale,
    output logic [qesm_pkg::NUM_SLOTS-1:0][qesm_pkg::CNT_W-1:0] o_pulses,
    output logic [qesm_pkg::NUM_SLOTS-1:0]                  o_reverse,
    output logic [qesm_pkg::NUM_SLOTS-1:0][qesm_pkg::SPD_W-1:0] o_speed,
    output logic                                            o_done
);
    import qesm_pkg::*;

    logic [NUM_SLOTS-1:0][CNT_W-1:0] r_pulses;
    logic [NUM_SLOTS-1:0]            r_reverse;
    logic [NUM_SLOTS-1:0][SPD_W-1:0] r_speed;
    logic                            r_done;

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_pulses[k]  <= i_lane[k].pulses;
                r_reverse[k] <= i_lane[k].reverse;
                r_speed[k]   <= SPD_W'(i_lane[k].pulses) * SPD_W'(i_scale);
            end
            r_done <= i_done;
        end
    end

    assign o_pulses  = r_pulses;
    assign o_reverse = r_reverse;
    assign o_speed   = r_speed;
    assign o_done    = r_done;

endmodule

// ===== src/quad_encoder_speed_meter_unit.sv =====
// Top level of the quadrature encoder speed meter: window timer, config regs,
// lanes and output pipeline. Depends on qesm_pkg, qesm_lane, qesm_merge.
//
// Usage:
//   Input channel (i_valid / o_stall): one word per sampling tick carrying
//   the A and B levels of three encoders. A word is taken at a clock edge
//   with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall): exactly one result word per input
//   word: held pulse counts, reverse flags, speeds and window_done.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 window_ticks,
//   1 idle_limit, 2 velocity_scale; other indexes are dropped. Always ready;
//   write only while the block is idle.
//   Timing: the accepting edge updates the lanes; the merge then loads the
//   speed multiply register once the output is free. Throughput:
//   one word per cycle while o_stall is low; the three lanes update together
//   and the three 16x16 multiplies run in the output stage in parallel.
//   Reset (sync, active low): all lane state, window timer and valids clear;
//   config regs return to 100 / 50 / 0.
//   Stall: when i_stall holds a full output register, the held stage fills
//   and o_stall rises one word later; no word is dropped or repeated.
module quad_encoder_speed_meter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample input
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_pin_a0,
    input  logic                             i_pin_b0,
    input  logic                             i_pin_a1,
    input  logic                             i_pin_b1,
    input  logic                             i_pin_a2,
    input  logic                             i_pin_b2,
    // result output
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [qesm_pkg::CNT_W-1:0]       o_pulses_0,
    output logic [qesm_pkg::CNT_W-1:0]       o_pulses_1,
    output logic [qesm_pkg::CNT_W-1:0]       o_pulses_2,
    output logic                             o_reverse_0,
    output logic                             o_reverse_1,
    output logic                             o_reverse_2,
    output logic [qesm_pkg::SPD_W-1:0]       o_speed_0,
    output logic [qesm_pkg::SPD_W-1:0]       o_speed_1,
    output logic [qesm_pkg::SPD_W-1:0]       o_speed_2,
    output logic                             o_window_done,
    // config write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qesm_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [qesm_pkg::CFG_W-1:0]       i_cfg_data
);
    import qesm_pkg::*;

    // config registers
    logic [WIN_W-1:0]  r_window_ticks;
    logic [IDLE_W-1:0] r_idle_limit;
    logic [CFG_W-1:0]  r_velocity_scale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks   <= RST_WINDOW_TICKS;
            r_idle_limit     <= RST_IDLE_LIMIT;
            r_velocity_scale <= RST_VELOCITY_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_TICKS:   r_window_ticks   <= i_cfg_data;
                CFG_IDLE_LIMIT:     r_idle_limit     <= i_cfg_data[IDLE_W-1:0];
                CFG_VELOCITY_SCALE: r_velocity_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline: stage 1 is the lane hold registers plus r_done (valid r_s1_valid),
    // stage 2 is the merge output register (valid r_out_valid).
    logic r_s1_valid;
    logic r_out_valid;
    logic r_done;
    logic w_out_free;
    logic w_s1_move;
    logic w_accept;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    // window timer; a zero length behaves as one since next >= 0 always holds
    logic [WIN_W-1:0] r_win_cnt;
    logic [WIN_W:0]   w_win_next;
    logic             w_latch;

    assign w_win_next = {1'b0, r_win_cnt} + (WIN_W+1)'(1);
    assign w_latch    = w_win_next >= {1'b0, r_window_ticks};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cnt   <= '0;
            r_done      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_win_cnt <= w_latch ? '0 : w_win_next[WIN_W-1:0];
                r_done    <= w_latch;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // lanes
    logic [NUM_SLOTS-1:0][1:0]        w_pins;
    t_lane_out [NUM_SLOTS-1:0]        w_lane;

    assign w_pins[0] = {i_pin_a0, i_pin_b0};
    assign w_pins[1] = {i_pin_a1, i_pin_b1};
    assign w_pins[2] = {i_pin_a2, i_pin_b2};

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_lane
        if (k < CHANNELS) begin : g_used
            qesm_lane u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (w_accept),
                .i_pins       (w_pins[k]),
                .i_idle_limit (r_idle_limit),
                .i_latch      (w_latch),
                .o_held       (w_lane[k])
            );
        end else begin : g_unused
            // channel not built: reports zero
            assign w_lane[k] = '0;
        end
    end

    // merge / speed scaling
    logic [NUM_SLOTS-1:0][CNT_W-1:0] w_pulses;
    logic [NUM_SLOTS-1:0]            w_reverse;
    logic [NUM_SLOTS-1:0][SPD_W-1:0] w_speed;

    qesm_merge u_merge (
        .i_clk     (i_clk),
        .i_load    (w_s1_move),
        .i_lane    (w_lane),
        .i_done    (r_done),
        .i_scale   (r_velocity_scale),
        .o_pulses  (w_pulses),
        .o_reverse (w_reverse),
        .o_speed   (w_speed),
        .o_done    (o_window_done)
    );

    assign o_valid     = r_out_valid;
    assign o_pulses_0  = w_pulses[0];
    assign o_pulses_1  = w_pulses[1];
    assign o_pulses_2  = w_pulses[2];
    assign o_reverse_0 = w_reverse[0];
    assign o_reverse_1 = w_reverse[1];
    assign o_reverse_2 = w_reverse[2];
    assign o_speed_0   = w_speed[0];
    assign o_speed_1   = w_speed[1];
    assign o_speed_2   = w_speed[2];

    // checks
`include "quad_encoder_speed_meter_unit_assert.svh"

    `QESM_ASSERT_NOW(a_stall_only_when_full, o_stall, r_s1_valid && r_out_valid, "stall while not full")
    `QESM_ASSERT_NEXT(a_done_forwarded, w_s1_move && r_done, o_valid && o_window_done, "window_done lost")
    `QESM_ASSERT_NEXT(a_timer_holds, !w_accept, $stable(r_win_cnt), "window timer moved without a word")

endmodule
